/* hdl/tpr_pkg.sv */
// Shared types and constants for the TLG5 pixel reconstruction core.
package tpr_pkg;

	localparam int unsigned LINE_DEPTH  = 4096;
	localparam int unsigned LINE_AW     = $clog2(LINE_DEPTH);
	localparam int unsigned QUEUE_DEPTH = 3;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned WIDTH_W    = 13;
	localparam int unsigned HEIGHT_W   = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_ENABLE = 2'd2;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic [7:0] alpha;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		pixel_t pix;
		logic   row_end;
		logic   frame_end;
	} out_word_t;

endpackage

/* hdl/tpr_stream_if.sv */
// Stream interfaces for input delta words and reconstructed pixel words.
interface tpr_pix_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue_delta;
	logic [7:0] green_delta;
	logic [7:0] red_delta;
	logic [7:0] alpha_delta;

	modport source (output valid, output blue_delta, output green_delta,
		output red_delta, output alpha_delta, input ready);
	modport sink (input valid, input blue_delta, input green_delta,
		input red_delta, input alpha_delta, output ready);
endinterface

interface tpr_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_blue;
	logic [7:0] out_green;
	logic [7:0] out_red;
	logic [7:0] out_alpha;
	logic       row_end;
	logic       frame_end;

	modport source (output valid, output out_blue, output out_green, output out_red,
		output out_alpha, output row_end, output frame_end, input ready);
	modport sink (input valid, input out_blue, input out_green, input out_red,
		input out_alpha, input row_end, input frame_end, output ready);
endinterface

/* hdl/tpr_line_mem.sv */
// Line store: one row of reconstructed pixels, synchronous read and write.
module tpr_line_mem (
	input  logic                         clk,
	input  logic                         we,
	input  logic [tpr_pkg::LINE_AW-1:0]  waddr,
	input  tpr_pkg::pixel_t              wdata,
	input  logic [tpr_pkg::LINE_AW-1:0]  raddr,
	output tpr_pkg::pixel_t              rdata
);

	tpr_pkg::pixel_t mem [tpr_pkg::LINE_DEPTH];
	tpr_pkg::pixel_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/tpr_out_queue.sv */
// Output queue decoupling the reconstruct stage from downstream stalls.
module tpr_out_queue (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  tpr_pkg::out_word_t            push_word,
	output logic [tpr_pkg::QUEUE_CW-1:0]  count,
	tpr_pix_out_if.source                 pix_out
);

	tpr_pkg::out_word_t               entry_q [tpr_pkg::QUEUE_DEPTH];
	logic [tpr_pkg::QUEUE_AW-1:0]     wr_ptr_q;
	logic [tpr_pkg::QUEUE_AW-1:0]     rd_ptr_q;
	logic [tpr_pkg::QUEUE_CW-1:0]     count_q;
	logic                             pop;
	tpr_pkg::out_word_t               head;

	localparam logic [tpr_pkg::QUEUE_AW-1:0] PTR_LAST =
		tpr_pkg::QUEUE_AW'(tpr_pkg::QUEUE_DEPTH - 1);

	assign pop  = (count_q != '0) && pix_out.ready;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign count             = count_q;
	assign pix_out.valid     = (count_q != '0);
	assign pix_out.out_blue  = head.pix.blue;
	assign pix_out.out_green = head.pix.green;
	assign pix_out.out_red   = head.pix.red;
	assign pix_out.out_alpha = head.pix.alpha;
	assign pix_out.row_end   = head.row_end;
	assign pix_out.frame_end = head.frame_end;

endmodule

/* hdl/tlg5_pixel_reconstruct_core.sv */
// TLG5 pixel reconstruction core: color transform, row sums, add of pixel above.
// Stage 1 registers each accepted word; it then goes to pix_out via the queue.
// One word per cycle while the queue has room; line store read at accept and
// written the cycle after, bypassed when the next word reads the same column.
// Reset: counters, row sums and registers to defaults (width 1, height 1, no
// alpha); the line store is not cleared, row 0 does not use what it reads.
module tlg5_pixel_reconstruct_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tpr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tpr_pkg::CFG_DATA_W-1:0]  cfg_data,
	tpr_pix_in_if.sink                      pix_in,
	tpr_pix_out_if.source                   pix_out
);

	logic [tpr_pkg::WIDTH_W-1:0]   width_q;
	logic [tpr_pkg::HEIGHT_W-1:0]  height_q;
	logic                          alpha_q;

	logic [tpr_pkg::LINE_AW-1:0]   col_q;
	logic [tpr_pkg::HEIGHT_W-1:0]  row_q;
	tpr_pkg::pixel_t               acc_q;

	logic                          valid_s1;
	tpr_pkg::pixel_t               acc_s1;
	logic [tpr_pkg::LINE_AW-1:0]   col_s1;
	logic                          above_en_s1;
	logic                          alpha_s1;
	logic                          row_end_s1;
	logic                          frame_end_s1;
	logic                          fwd_s1;
	tpr_pkg::pixel_t               fwd_data_s1;

	logic [tpr_pkg::WIDTH_W-1:0]   width_m1;
	logic [tpr_pkg::LINE_AW-1:0]   col_last;
	logic [tpr_pkg::HEIGHT_W-1:0]  row_last;
	logic [tpr_pkg::LINE_AW-1:0]   col;
	logic                          last_col;
	logic                          last_row;
	logic                          accept;
	tpr_pkg::pixel_t               acc_base;
	tpr_pkg::pixel_t               acc_next;
	logic [7:0]                    green;

	tpr_pkg::pixel_t               mem_rdata;
	tpr_pkg::pixel_t               above;
	tpr_pkg::pixel_t               result_s1;
	tpr_pkg::out_word_t            word_s1;
	logic [tpr_pkg::QUEUE_CW-1:0]  q_count;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tpr_pkg::WIDTH_W'(1);
			height_q <= tpr_pkg::HEIGHT_W'(1);
			alpha_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				tpr_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data[tpr_pkg::WIDTH_W-1:0];
				tpr_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data[tpr_pkg::HEIGHT_W-1:0];
				tpr_pkg::CFG_ALPHA_ENABLE: alpha_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// position and row sums
	assign width_m1 = width_q - 1'b1;
	assign col_last = (width_q == '0) ? '0 :
		(width_q[tpr_pkg::WIDTH_W-1] ? '1 : width_m1[tpr_pkg::LINE_AW-1:0]);
	assign row_last = (height_q == '0) ? '0 : height_q - 1'b1;
	assign col      = (col_q > col_last) ? col_last : col_q;
	assign last_col = (col == col_last);
	assign last_row = (row_q >= row_last);

	assign pix_in.ready = (q_count + tpr_pkg::QUEUE_CW'(valid_s1)) <
		tpr_pkg::QUEUE_CW'(tpr_pkg::QUEUE_DEPTH);
	assign accept = pix_in.valid && pix_in.ready;

	assign green    = pix_in.green_delta;
	assign acc_base = (col == '0) ? '0 : acc_q;

	always_comb begin
		acc_next.blue  = acc_base.blue  + pix_in.blue_delta + green;
		acc_next.green = acc_base.green + green;
		acc_next.red   = acc_base.red   + pix_in.red_delta + green;
		acc_next.alpha = alpha_q ? acc_base.alpha + pix_in.alpha_delta : acc_base.alpha;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			acc_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				acc_q <= acc_next;
				col_q <= last_col ? '0 : col + 1'b1;
				if (last_col) begin
					row_q <= last_row ? '0 : row_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_s1       <= acc_next;
			col_s1       <= col;
			above_en_s1  <= (row_q != '0);
			alpha_s1     <= alpha_q;
			row_end_s1   <= last_col;
			frame_end_s1 <= last_col && last_row;
			fwd_s1       <= valid_s1 && (col_s1 == col);
			fwd_data_s1  <= result_s1;
		end
	end

	// line store read at accept, write back from stage 1
	tpr_line_mem u_line_mem (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (col_s1),
		.wdata (result_s1),
		.raddr (col),
		.rdata (mem_rdata)
	);

	always_comb begin
		if (!above_en_s1) begin
			above = '0;
		end else if (fwd_s1) begin
			above = fwd_data_s1;
		end else begin
			above = mem_rdata;
		end
		result_s1.blue  = acc_s1.blue  + above.blue;
		result_s1.green = acc_s1.green + above.green;
		result_s1.red   = acc_s1.red   + above.red;
		result_s1.alpha = alpha_s1 ? acc_s1.alpha + above.alpha : tpr_pkg::ALPHA_OPAQUE;
		word_s1.pix       = result_s1;
		word_s1.row_end   = row_end_s1;
		word_s1.frame_end = frame_end_s1;
	end

	tpr_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_word (word_s1),
		.count     (q_count),
		.pix_out   (pix_out)
	);

endmodule
